// ===== rtl/tars_pkg.sv =====
// shared types and constants for the torus adaptive route select block
`default_nettype none

package tars_pkg;

   localparam int COORD_W  = 4;
   localparam int RADIX_W  = 5;
   localparam int SPACE_W  = 8;
   localparam int TOTAL_W  = SPACE_W + 1;
   localparam int DIS_W    = COORD_W + 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 8;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RADIX     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MSG_LEN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_MODE = 3'd4;

   // reset values of the configuration registers
   localparam logic [COORD_W-1:0] NODE_RESET   = 4'd0;
   localparam logic [RADIX_W-1:0] RADIX_RESET  = 5'd8;
   localparam logic [SPACE_W-1:0] MSG_LEN_RESET = 8'd16;

   // output direction codes
   localparam logic [1:0] DIR_XNEG = 2'd0;
   localparam logic [1:0] DIR_XPOS = 2'd1;
   localparam logic [1:0] DIR_YNEG = 2'd2;
   localparam logic [1:0] DIR_YPOS = 2'd3;

   localparam logic CHAN_FIRST = 1'b0;

   // one captured request beat
   typedef struct packed {
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
      logic [SPACE_W-1:0] xneg_a;
      logic [SPACE_W-1:0] xneg_b;
      logic [SPACE_W-1:0] xpos_a;
      logic [SPACE_W-1:0] xpos_b;
      logic [SPACE_W-1:0] yneg_a;
      logic [SPACE_W-1:0] yneg_b;
      logic [SPACE_W-1:0] ypos_a;
      logic [SPACE_W-1:0] ypos_b;
      logic [3:0]         link_busy;
   } req_type;

   // verdict of one dimension
   typedef struct packed {
      logic               ok;
      logic               pos;    // 1 positive direction, 0 negative
      logic               chan;
      logic [TOTAL_W-1:0] total;
   } dim_pick_type;

endpackage

`default_nettype wire

// ===== rtl/tars_dim_pick.sv =====
// direction and channel choice for one torus dimension
`default_nettype none

module tars_dim_pick
   import tars_pkg::*;
(
   input  wire logic signed [DIS_W-1:0] dis,
   input  wire logic [COORD_W-1:0]      cur,
   input  wire logic [RADIX_W-1:0]      radix,
   input  wire logic                    spec_rest,
   input  wire logic                    dateline_en,
   input  wire logic [SPACE_W-1:0]      neg_a,
   input  wire logic [SPACE_W-1:0]      neg_b,
   input  wire logic [SPACE_W-1:0]      pos_a,
   input  wire logic [SPACE_W-1:0]      pos_b,
   input  wire logic [1:0]              busy2,
   input  wire logic [SPACE_W-1:0]      msg_len,
   output dim_pick_type                 pick
);

   logic signed [DIS_W-1:0] half_s;
   logic                    over_pos;
   logic                    over_neg;
   logic                    wrap;
   logic                    d;
   logic                    special;
   logic [SPACE_W-1:0]      sa;
   logic [SPACE_W-1:0]      sb;

   always_comb begin
      half_s   = signed'({2'b00, radix[RADIX_W-1:1]});
      over_pos = dis > half_s;
      over_neg = dis < -half_s;
      wrap     = over_pos | over_neg;
      d        = (dis > 0) != wrap;
      sa       = d ? pos_a : neg_a;
      sb       = d ? pos_b : neg_b;
      // dateline crossings and the escape rule open the second channel
      special  = dateline_en & (spec_rest |
                 (over_pos & (cur == '0)) |
                 (over_neg & ({1'b0, cur} == radix - RADIX_W'(1))));
      pick.pos   = d;
      pick.total = {1'b0, sa} + {1'b0, sb};
      pick.ok    = 1'b0;
      pick.chan  = CHAN_FIRST;
      if (dis != '0 && !busy2[d]) begin
         if (sa >= msg_len) begin
            pick.ok = 1'b1;
         end else if (special && sb >= msg_len) begin
            pick.ok   = 1'b1;
            pick.chan = ~CHAN_FIRST;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/torus_adaptive_route_select.sv =====
// top level: route selection for one router of a two-dimensional torus
// a result strobes on rsp_valid once the start beat has passed the input and result registers
// throughput: one beat per cycle; busy is high only during reset
// one input register, shallow compare/add logic, one result register
// reset clears the valid pipeline and loads the configuration defaults
// the receiver cannot stall, so no result is ever held back
`default_nettype none

module torus_adaptive_route_select
   import tars_pkg::*;
#(
   parameter int unsigned MAX_RADIX = 16,
   parameter int unsigned SPACE_MAX = 255
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   // request channel
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic [COORD_W-1:0]    req_dest_x,
   input  wire logic [COORD_W-1:0]    req_dest_y,
   input  wire logic [SPACE_W-1:0]    req_xneg_space_a,
   input  wire logic [SPACE_W-1:0]    req_xneg_space_b,
   input  wire logic [SPACE_W-1:0]    req_xpos_space_a,
   input  wire logic [SPACE_W-1:0]    req_xpos_space_b,
   input  wire logic [SPACE_W-1:0]    req_yneg_space_a,
   input  wire logic [SPACE_W-1:0]    req_yneg_space_b,
   input  wire logic [SPACE_W-1:0]    req_ypos_space_a,
   input  wire logic [SPACE_W-1:0]    req_ypos_space_b,
   input  wire logic [3:0]            req_link_busy,

   // result channel
   output      logic                  rsp_valid,
   output      logic                  rsp_route_found,
   output      logic [1:0]            rsp_out_direction,
   output      logic                  rsp_out_channel,

   // configuration write channel
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // a radix cap above what the register can hold is limited to 31
   localparam int unsigned RADIX_LIM = (MAX_RADIX > 31) ? 31 : MAX_RADIX;
   localparam logic [RADIX_W-1:0] RADIX_CAP = RADIX_W'(RADIX_LIM);
   // 8-bit space fields only saturate when the cap is below their range
   localparam logic [SPACE_W-1:0] SPACE_CAP =
      SPACE_W'((SPACE_MAX > 255) ? 255 : SPACE_MAX);

   // configuration registers
   logic [COORD_W-1:0] node_x_ff;
   logic [COORD_W-1:0] node_y_ff;
   logic [RADIX_W-1:0] radix_ff;
   logic [SPACE_W-1:0] msg_len_ff;
   logic               flow_mode_ff;

   // input stage
   logic    accept;
   req_type req_in;
   req_type req_ff;
   logic    stage_valid_ff;

   // result stage
   logic       rsp_valid_ff;
   logic       found_ff;
   logic [1:0] dir_ff;
   logic       chan_ff;
   logic       found_in;
   logic [1:0] dir_in;
   logic       chan_in;

   // per-dimension working values
   logic [RADIX_W-1:0]         radix_k;
   logic signed [DIS_W-1:0]    half_s;
   logic signed [DIS_W-1:0]    xdis;
   logic signed [DIS_W-1:0]    ydis;
   logic                       xin;
   logic                       yin;
   logic                       x_rest;
   logic                       y_rest;
   logic [SPACE_W-1:0]         sp [8];
   dim_pick_type               xpick;
   dim_pick_type               ypick;

   assign busy      = reset;
   assign csr_ready = ~reset;
   assign accept    = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_x_ff    <= NODE_RESET;
         node_y_ff    <= NODE_RESET;
         radix_ff     <= RADIX_RESET;
         msg_len_ff   <= MSG_LEN_RESET;
         flow_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NODE_X:    node_x_ff    <= csr_wdata[COORD_W-1:0];
            CSR_NODE_Y:    node_y_ff    <= csr_wdata[COORD_W-1:0];
            CSR_RADIX:     radix_ff     <= csr_wdata[RADIX_W-1:0];
            CSR_MSG_LEN:   msg_len_ff   <= csr_wdata[SPACE_W-1:0];
            CSR_FLOW_MODE: flow_mode_ff <= csr_wdata[0];
            default: ;     // unused indexes are dropped
         endcase
      end
   end

   // gather the request beat
   always_comb begin
      req_in.dest_x    = req_dest_x;
      req_in.dest_y    = req_dest_y;
      req_in.xneg_a    = req_xneg_space_a;
      req_in.xneg_b    = req_xneg_space_b;
      req_in.xpos_a    = req_xpos_space_a;
      req_in.xpos_b    = req_xpos_space_b;
      req_in.yneg_a    = req_yneg_space_a;
      req_in.yneg_b    = req_yneg_space_b;
      req_in.ypos_a    = req_ypos_space_a;
      req_in.ypos_b    = req_ypos_space_b;
      req_in.link_busy = req_link_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
   end

   // clamp radix, saturate space, form offsets
   always_comb begin
      if (radix_ff < RADIX_W'(2)) begin
         radix_k = RADIX_W'(2);
      end else if (radix_ff > RADIX_CAP) begin
         radix_k = RADIX_CAP;
      end else begin
         radix_k = radix_ff;
      end
      half_s = signed'({2'b00, radix_k[RADIX_W-1:1]});

      sp[0] = (req_ff.xneg_a > SPACE_CAP) ? SPACE_CAP : req_ff.xneg_a;
      sp[1] = (req_ff.xneg_b > SPACE_CAP) ? SPACE_CAP : req_ff.xneg_b;
      sp[2] = (req_ff.xpos_a > SPACE_CAP) ? SPACE_CAP : req_ff.xpos_a;
      sp[3] = (req_ff.xpos_b > SPACE_CAP) ? SPACE_CAP : req_ff.xpos_b;
      sp[4] = (req_ff.yneg_a > SPACE_CAP) ? SPACE_CAP : req_ff.yneg_a;
      sp[5] = (req_ff.yneg_b > SPACE_CAP) ? SPACE_CAP : req_ff.yneg_b;
      sp[6] = (req_ff.ypos_a > SPACE_CAP) ? SPACE_CAP : req_ff.ypos_a;
      sp[7] = (req_ff.ypos_b > SPACE_CAP) ? SPACE_CAP : req_ff.ypos_b;

      // plain differences, no modulo reduction
      xdis = signed'({2'b00, req_ff.dest_x}) - signed'({2'b00, node_x_ff});
      ydis = signed'({2'b00, req_ff.dest_y}) - signed'({2'b00, node_y_ff});

      xin = (xdis <= half_s) && (xdis >= -half_s);
      yin = (ydis <= half_s) && (ydis >= -half_s);

      // escape rule: x when neither wraps, y also needs the flow condition
      x_rest = xin & yin;
      y_rest = xin & yin & (flow_mode_ff ? (xdis == '0) : (xdis >= 0));
   end

   tars_dim_pick u_pick_x (
      .dis         (xdis),
      .cur         (node_x_ff),
      .radix       (radix_k),
      .spec_rest   (x_rest),
      .dateline_en (1'b1),
      .neg_a       (sp[0]),
      .neg_b       (sp[1]),
      .pos_a       (sp[2]),
      .pos_b       (sp[3]),
      .busy2       (req_ff.link_busy[1:0]),
      .msg_len     (msg_len_ff),
      .pick        (xpick)
   );

   // when x wraps, y is restricted to its first channel
   tars_dim_pick u_pick_y (
      .dis         (ydis),
      .cur         (node_y_ff),
      .radix       (radix_k),
      .spec_rest   (y_rest),
      .dateline_en (xin),
      .neg_a       (sp[4]),
      .neg_b       (sp[5]),
      .pos_a       (sp[6]),
      .pos_b       (sp[7]),
      .busy2       (req_ff.link_busy[3:2]),
      .msg_len     (msg_len_ff),
      .pick        (ypick)
   );

   // arbitration between the dimensions: x wins ties on total free space
   always_comb begin
      found_in = 1'b0;
      dir_in   = DIR_XNEG;
      chan_in  = CHAN_FIRST;
      if (xpick.ok && (!ypick.ok || xpick.total >= ypick.total)) begin
         found_in = 1'b1;
         dir_in   = xpick.pos ? DIR_XPOS : DIR_XNEG;
         chan_in  = xpick.chan;
      end else if (ypick.ok) begin
         found_in = 1'b1;
         dir_in   = ypick.pos ? DIR_YPOS : DIR_YNEG;
         chan_in  = ypick.chan;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid_ff) begin
         found_ff <= found_in;
         dir_ff   <= dir_in;
         chan_ff  <= chan_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_route_found   = found_ff;
   assign rsp_out_direction = dir_ff;
   assign rsp_out_channel   = chan_ff;

   // every accepted beat yields exactly one result, through the input and result registers
   a_two_cycle_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##2 rsp_valid)
      else $error("accepted beat produced no result");

   // a refused route carries zero direction and channel
   a_no_route_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_route_found) |->
         (rsp_out_direction == DIR_XNEG && rsp_out_channel == CHAN_FIRST))
      else $error("no-route result has nonzero fields");

   // a granted direction was not marked busy in its request
   a_not_busy_link: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_route_found) |->
         ((($past(req_ff.link_busy) >> rsp_out_direction) & 4'd1) == 4'd0))
      else $error("route granted on a busy link");

endmodule

`default_nettype wire

// ===== test/route_checker.sv =====
// checker for the torus route selector: predicts each grant and compares it with the block
module route_checker
   import tars_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  req_type               req_beat,
   input  logic                  rsp_valid,
   input  logic                  rsp_route_found,
   input  logic [1:0]            rsp_out_direction,
   input  logic                  rsp_out_channel,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    outstanding,
   output int                    checked_count,
   output int                    granted_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_RADIX   = 16;
   localparam int PRINT_LIMIT = 40;

   typedef struct packed {
      logic       found;
      logic [1:0] direction;
      logic       channel;
   } route_grant_t;

   logic [COORD_W-1:0] node_x;
   logic [COORD_W-1:0] node_y;
   logic [RADIX_W-1:0] radix;
   logic [SPACE_W-1:0] msg_len;
   logic               flow_mode;
   route_grant_t       pending_grants[$];

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_LIMIT)
         $display("checker: beat %0d: %s", checked_count, what);
      fail_count++;
   endtask

   // one dimension: minimal direction, busy refusal, first channel or dateline/escape second
   function automatic dim_pick_type pick_link(
      input int dis, input int cur, input int k, input logic escape,
      input logic [SPACE_W-1:0] neg_a, neg_b, pos_a, pos_b,
      input logic [1:0] link_busy);
      int half;
      logic dateline;
      logic [SPACE_W-1:0] room_a;
      logic [SPACE_W-1:0] room_b;
      dim_pick_type p;
      half = k / 2;
      p = '0;
      if (dis == 0)
         return p;
      p.pos = (dis > 0) != ((dis > half) || (dis < -half));
      if (link_busy[p.pos])
         return '0;
      dateline = escape || (dis > half && cur == 0) || (dis < -half && cur == k - 1);
      room_a = p.pos ? pos_a : neg_a;
      room_b = p.pos ? pos_b : neg_b;
      if (room_a >= msg_len)
         p.chan = CHAN_FIRST;
      else if (dateline && room_b >= msg_len)
         p.chan = ~CHAN_FIRST;
      else
         return '0;
      p.ok = 1'b1;
      p.total = TOTAL_W'(room_a) + TOTAL_W'(room_b);
      return p;
   endfunction

   function automatic route_grant_t predict_grant(input req_type r);
      int k;
      int half;
      int xdis;
      int ydis;
      logic xin;
      logic yin;
      logic y_escape;
      logic [SPACE_W-1:0] ya;
      logic [SPACE_W-1:0] yb;
      dim_pick_type xp;
      dim_pick_type yp;
      route_grant_t g;
      k = (radix < 2) ? 2 : (radix > MAX_RADIX) ? MAX_RADIX : int'(radix);
      half = k / 2;
      xdis = int'(r.dest_x) - int'(node_x);
      ydis = int'(r.dest_y) - int'(node_y);
      xin = (xdis <= half) && (xdis >= -half);
      yin = (ydis <= half) && (ydis >= -half);
      xp = pick_link(xdis, int'(node_x), k, xin && yin, r.xneg_a, r.xneg_b,
                     r.xpos_a, r.xpos_b, r.link_busy[1:0]);
      y_escape = xin && yin && (flow_mode ? (xdis == 0) : (xdis >= 0));
      if (xin || ydis == 0) begin
         yp = pick_link(ydis, int'(node_y), k, y_escape, r.yneg_a, r.yneg_b,
                        r.ypos_a, r.ypos_b, r.link_busy[3:2]);
      end else begin
         // x wraps around: y may only use its first channel
         yp = '0;
         yp.pos = (ydis > 0) == yin;
         ya = yp.pos ? r.ypos_a : r.yneg_a;
         yb = yp.pos ? r.ypos_b : r.yneg_b;
         if (!r.link_busy[2 + yp.pos] && ya >= msg_len) begin
            yp.ok = 1'b1;
            yp.chan = CHAN_FIRST;
            yp.total = TOTAL_W'(ya) + TOTAL_W'(yb);
         end
      end
      g = '{found: 1'b0, direction: DIR_XNEG, channel: CHAN_FIRST};
      if (xp.ok && (!yp.ok || xp.total >= yp.total))
         g = '{found: 1'b1, direction: xp.pos ? DIR_XPOS : DIR_XNEG, channel: xp.chan};
      else if (yp.ok)
         g = '{found: 1'b1, direction: yp.pos ? DIR_YPOS : DIR_YNEG, channel: yp.chan};
      return g;
   endfunction

   always @(posedge clock) begin
      route_grant_t want;
      if (reset) begin
         node_x = NODE_RESET;
         node_y = NODE_RESET;
         radix = RADIX_RESET;
         msg_len = MSG_LEN_RESET;
         flow_mode = 1'b0;
         pending_grants.delete();
      end else begin
         if (rsp_valid) begin
            if (pending_grants.size() == 0) begin
               report_mismatch($sformatf("result with nothing expected: found %0b dir %0d chan %0b",
                                         rsp_route_found, rsp_out_direction, rsp_out_channel));
            end else begin
               want = pending_grants.pop_front();
               if (rsp_route_found != want.found)
                  report_mismatch($sformatf("route_found expected %0b got %0b",
                                            want.found, rsp_route_found));
               if (rsp_out_direction != want.direction)
                  report_mismatch($sformatf("out_direction expected %0d got %0d",
                                            want.direction, rsp_out_direction));
               if (rsp_out_channel != want.channel)
                  report_mismatch($sformatf("out_channel expected %0b got %0b",
                                            want.channel, rsp_out_channel));
               checked_count++;
               if (want.found)
                  granted_count++;
            end
         end
         if (start && !busy)
            pending_grants.push_back(predict_grant(req_beat));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_NODE_X:    node_x = csr_wdata[COORD_W-1:0];
               CSR_NODE_Y:    node_y = csr_wdata[COORD_W-1:0];
               CSR_RADIX:     radix = csr_wdata[RADIX_W-1:0];
               CSR_MSG_LEN:   msg_len = csr_wdata[SPACE_W-1:0];
               CSR_FLOW_MODE: flow_mode = csr_wdata[0];
               default: ;
            endcase
         end
      end
      outstanding <= pending_grants.size();
   end

endmodule

// ===== test/tb_top.sv =====
// testbench top: drives route requests and register writes, then gives the verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tars_pkg::*;

   localparam int STALL_LIMIT     = 1000;   // cycles with no beat at all before giving up
   localparam int SETTLE_CYCLES   = 8;      // idle margin after the drain, before the verdict
   localparam int BEATS_PER_PHASE = 45;
   localparam int NUM_PHASES      = 10;
   localparam int BURST_PHASE     = 5;      // this phase runs with no idle cycles
   localparam int FULL            = 255;
   localparam int IDLE_PERCENT    = 38;

   typedef struct {
      logic [COORD_W-1:0] node_x;
      logic [COORD_W-1:0] node_y;
      logic [RADIX_W-1:0] radix;
      logic [SPACE_W-1:0] msg_len;
      logic               flow_mode;
   } route_setting_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               beat = '0;
   logic                  rsp_valid;
   logic                  rsp_route_found;
   logic [1:0]            rsp_out_direction;
   logic                  rsp_out_channel;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int             fail_count;
   int             outstanding;
   int             checked_count;
   int             granted_count;
   int             stall_cycles = 0;
   int             settings_used = 1;   // the reset defaults count as one
   logic           idle_on = 1'b1;
   route_setting_t setting;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   torus_adaptive_route_select DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_dest_x        (beat.dest_x),
      .req_dest_y        (beat.dest_y),
      .req_xneg_space_a  (beat.xneg_a),
      .req_xneg_space_b  (beat.xneg_b),
      .req_xpos_space_a  (beat.xpos_a),
      .req_xpos_space_b  (beat.xpos_b),
      .req_yneg_space_a  (beat.yneg_a),
      .req_yneg_space_b  (beat.yneg_b),
      .req_ypos_space_a  (beat.ypos_a),
      .req_ypos_space_b  (beat.ypos_b),
      .req_link_busy     (beat.link_busy),
      .rsp_valid         (rsp_valid),
      .rsp_route_found   (rsp_route_found),
      .rsp_out_direction (rsp_out_direction),
      .rsp_out_channel   (rsp_out_channel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   route_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_beat          (beat),
      .rsp_valid         (rsp_valid),
      .rsp_route_found   (rsp_route_found),
      .rsp_out_direction (rsp_out_direction),
      .rsp_out_channel   (rsp_out_channel),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .outstanding       (outstanding),
      .checked_count     (checked_count),
      .granted_count     (granted_count)
   );

   // watchdog: any accepted beat on any channel restarts the count
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready) || reset) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // free space near the message length, so first/second channel choices flip often
   function automatic logic [SPACE_W-1:0] near_room(input logic [SPACE_W-1:0] len);
      int v;
      case ($urandom_range(3))
         0: v = 0;
         1: v = FULL;
         2: v = int'(len) + int'($urandom_range(2)) - 1;
         default: v = int'($urandom_range(FULL));
      endcase
      if (v < 0)
         v = 0;
      if (v > FULL)
         v = FULL;
      return SPACE_W'(v);
   endfunction

   // random request shaped by the active setting: most destinations land inside the torus
   function automatic req_type random_beat();
      req_type r;
      int k;
      k = (setting.radix < 2) ? 2 : (setting.radix > 16) ? 16 : int'(setting.radix);
      r.dest_x = ($urandom_range(3) != 0) ? COORD_W'($urandom_range(k - 1)) : COORD_W'($urandom);
      r.dest_y = ($urandom_range(3) != 0) ? COORD_W'($urandom_range(k - 1)) : COORD_W'($urandom);
      r.xneg_a = near_room(setting.msg_len);
      r.xneg_b = near_room(setting.msg_len);
      r.xpos_a = near_room(setting.msg_len);
      r.xpos_b = near_room(setting.msg_len);
      r.yneg_a = near_room(setting.msg_len);
      r.yneg_b = near_room(setting.msg_len);
      r.ypos_a = near_room(setting.msg_len);
      r.ypos_b = near_room(setting.msg_len);
      // half of the beats see every link free
      r.link_busy = $urandom_range(1) ? 4'h0 : 4'($urandom);
      return r;
   endfunction

   function automatic req_type route_req(input int dx, dy, xna, xnb, xpa, xpb,
                                          yna, ynb, ypa, ypb, busy_mask);
      req_type r;
      r.dest_x = COORD_W'(dx);
      r.dest_y = COORD_W'(dy);
      r.xneg_a = SPACE_W'(xna);
      r.xneg_b = SPACE_W'(xnb);
      r.xpos_a = SPACE_W'(xpa);
      r.xpos_b = SPACE_W'(xpb);
      r.yneg_a = SPACE_W'(yna);
      r.yneg_b = SPACE_W'(ynb);
      r.ypos_a = SPACE_W'(ypa);
      r.ypos_b = SPACE_W'(ypb);
      r.link_busy = 4'(busy_mask);
      return r;
   endfunction

   // one request beat; junk rides on the payload while start is low
   task automatic send_beat(input req_type r);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         start <= 1'b0;
         beat <= random_beat();
         @(posedge clock);
      end
      start <= 1'b1;
      beat <= r;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // one register write beat; valid stays up for a following write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         csr_valid <= 1'b0;
         @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
   endtask

   // stop requests and wait for every predicted grant to come back
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   // registers change only with the block idle; unused upper data bits carry noise
   task automatic apply_setting(input route_setting_t s);
      drain();
      write_reg(CSR_NODE_X, {4'($urandom), s.node_x});
      write_reg(CSR_NODE_Y, {4'($urandom), s.node_y});
      write_reg(CSR_RADIX, {3'($urandom), s.radix});
      write_reg(CSR_MSG_LEN, s.msg_len);
      write_reg(CSR_FLOW_MODE, {7'($urandom), s.flow_mode});
      // an index past the last register must leave every setting alone
      write_reg(CSR_IDX_W'(int'(CSR_FLOW_MODE) + 1 + int'($urandom_range(2))), 8'($urandom));
      csr_valid <= 1'b0;
      setting = s;
      settings_used++;
   endtask

   initial begin
      route_setting_t s;
      setting = '{NODE_RESET, NODE_RESET, RADIX_RESET, MSG_LEN_RESET, 1'b0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: node (0,0), radix 8, message length 16, flow mode 0
      // destination is this node: no route
      send_beat(route_req(0, 0, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 0));
      // one hop east on the first channel
      send_beat(route_req(1, 0, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 0));
      // x offset past half wraps west; dateline at x 0 opens the second channel
      send_beat(route_req(7, 0, 0, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 0));
      // coordinate beyond the radix, no modulo reduction
      send_beat(route_req(15, 0, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 0));
      // both dimensions qualify with equal totals: x wins the tie
      send_beat(route_req(1, 1, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 0));
      // y has more total free space
      send_beat(route_req(1, 1, FULL, FULL, 16, 0, FULL, FULL, FULL, FULL, 0));
      // busy x link pushes the beat onto y
      send_beat(route_req(1, 1, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 4'b0010));
      // every link busy
      send_beat(route_req(1, 1, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 4'b1111));
      // no free space anywhere
      send_beat(route_req(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // x wraps and its link is busy: y gets the first channel
      send_beat(route_req(7, 2, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 4'b0001));
      // x wraps: y may not fall back to its second channel
      send_beat(route_req(7, 2, FULL, FULL, FULL, FULL, FULL, FULL, 0, FULL, 4'b0001));
      // y escape with nonnegative x offset
      send_beat(route_req(1, 1, FULL, FULL, FULL, FULL, FULL, FULL, 0, FULL, 4'b0010));
      // offsets exactly at half stay minimal, one past half wraps
      send_beat(route_req(0, 4, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 0));
      send_beat(route_req(0, 5, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 0));
      send_beat(route_req(4, 0, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 0));
      // y wraps with x at zero: y dateline at y 0
      send_beat(route_req(0, 12, FULL, FULL, FULL, FULL, FULL, 0, FULL, FULL, 0));

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: ;
            1: begin
               // node at radix-1 on both axes, longest messages, strict escape rule
               apply_setting('{4'd7, 4'd7, 5'd8, 8'd255, 1'b1});
               // negative wrap from the last column: dateline on the second channel
               send_beat(route_req(0, 7, FULL, FULL, 0, FULL, FULL, FULL, FULL, FULL, 0));
               // zero x offset allows the y escape under the strict rule
               send_beat(route_req(7, 6, FULL, FULL, FULL, FULL, 0, FULL, FULL, FULL, 0));
               // negative x offset: no y escape, x takes its second channel
               send_beat(route_req(6, 6, 0, FULL, FULL, FULL, 0, FULL, FULL, FULL, 0));
               // both dimensions wrap
               send_beat(route_req(15, 15, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 0));
            end
            2: begin
               // radix above the maximum saturates; zero message length always fits
               apply_setting('{4'd15, 4'd15, 5'd31, 8'd0, 1'b0});
               send_beat(route_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
               send_beat(route_req(15, 15, 0, 0, 0, 0, 0, 0, 0, 0, 0));
               send_beat(route_req(7, 15, 0, 0, 0, 0, 0, 0, 0, 0, 4'b0011));
            end
            3: begin
               // radix zero saturates to two, coordinates far outside the torus
               apply_setting('{4'd3, 4'd12, 5'd0, 8'd255, 1'b0});
               send_beat(route_req(15, 0, FULL, FULL, FULL, FULL, FULL, FULL, FULL, FULL, 0));
            end
            4: apply_setting('{4'd0, 4'd15, 5'd16, 8'd1, 1'b0});
            default: begin
               s.node_x = COORD_W'($urandom);
               s.node_y = COORD_W'($urandom);
               s.radix = ($urandom_range(4) == 0) ? RADIX_W'($urandom) : RADIX_W'($urandom_range(2, 16));
               case ($urandom_range(3))
                  0: s.msg_len = 8'd0;
                  1: s.msg_len = 8'd1;
                  2: s.msg_len = 8'd255;
                  default: s.msg_len = 8'($urandom);
               endcase
               s.flow_mode = 1'($urandom);
               apply_setting(s);
            end
         endcase
         // one phase runs back to back to exercise full-rate acceptance
         idle_on = (phase != BURST_PHASE);
         repeat (BEATS_PER_PHASE)
            send_beat(random_beat());
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("summary: %0d route requests checked, %0d of them granted a link",
               checked_count, granted_count);
      $display("summary: %0d register settings incl. radix and length extremes, one burst phase",
               settings_used);
      if (fail_count == 0 && outstanding == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
